/* design/cvf_pkg.sv */
// Shared types, widths and helpers for the canyon view factor pipeline.
package cvf_pkg;

  localparam int unsigned DimBits    = 18;  // height, width and threshold width
  localparam int unsigned OutBits    = 17;  // view factor field width
  localparam int unsigned NormBits   = 31;  // normalized dimension, top bit at 30
  localparam int unsigned SqBits     = 2 * NormBits;
  localparam int unsigned RadBits    = 64;  // radicand, padded to an even width
  localparam int unsigned RootBits   = RadBits / 2;
  localparam int unsigned SqRemBits  = RootBits + 2;
  localparam int unsigned DenBits    = RootBits + 1;
  localparam int unsigned SqrtSteps  = RootBits;
  localparam int unsigned LzBits     = 5;

  typedef enum logic [1:0] {
    ClassNonUrban   = 2'd0,
    ClassDegenerate = 2'd1,
    ClassRegular    = 2'd2
  } cell_class_e;

  typedef struct packed {
    logic               urban_flag;
    logic [DimBits-1:0] building_height;
    logic [DimBits-1:0] road_width;
  } in_item_t;

  typedef struct packed {
    logic [OutBits-1:0] wall_to_sky;
    logic [OutBits-1:0] wall_to_wall;
    logic [OutBits-1:0] wall_to_road;
    logic [OutBits-1:0] road_to_sky;
    logic [OutBits-1:0] road_to_wall;
    cell_class_e        cell_class;
  } out_item_t;

  // Sideband that rides along the square root chain.
  typedef struct packed {
    cell_class_e         cls;
    logic [NormBits-1:0] hn;
    logic [NormBits-1:0] wn;
  } sqrt_side_t;

  // Count of leading zeros in a dimension; a zero value gives an unused count.
  function automatic logic [LzBits-1:0] lead_zeros(logic [DimBits-1:0] v);
    logic [LzBits-1:0] lz;
    lz = '0;
    for (int i = 0; i < DimBits; i++) begin
      if (v[i]) begin
        lz = LzBits'(DimBits - 1 - i);
      end
    end
    return lz;
  endfunction

endpackage

/* design/cvf_sqrt_cell.sv */
// One step of the restoring square root: consumes two radicand bits, yields one root bit.
module cvf_sqrt_cell (
  input  logic                           clk_i,
  input  logic                           en_i,
  input  logic [cvf_pkg::RadBits-1:0]    rad_i,
  input  logic [cvf_pkg::SqRemBits-1:0]  rem_i,
  input  logic [cvf_pkg::RootBits-1:0]   root_i,
  output logic [cvf_pkg::RadBits-1:0]    rad_o,
  output logic [cvf_pkg::SqRemBits-1:0]  rem_o,
  output logic [cvf_pkg::RootBits-1:0]   root_o
);

  localparam int unsigned ExtBits = cvf_pkg::SqRemBits + 2;

  logic [cvf_pkg::RadBits-1:0]   rad_d, rad_q;
  logic [cvf_pkg::SqRemBits-1:0] rem_d, rem_q;
  logic [cvf_pkg::RootBits-1:0]  root_d, root_q;
  logic [ExtBits-1:0]            rem_ext, trial, diff;
  logic                          take;

  always_comb begin
    rem_ext = {rem_i, rad_i[cvf_pkg::RadBits-1 -: 2]};
    trial   = {2'b00, root_i, 2'b01};
    diff    = rem_ext - trial;
    take    = (rem_ext >= trial);
    rem_d   = take ? diff[cvf_pkg::SqRemBits-1:0] : rem_ext[cvf_pkg::SqRemBits-1:0];
    root_d  = {root_i[cvf_pkg::RootBits-2:0], take};
    rad_d   = {rad_i[cvf_pkg::RadBits-3:0], 2'b00};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rad_q  <= rad_d;
      rem_q  <= rem_d;
      root_q <= root_d;
    end
  end

  assign rad_o  = rad_q;
  assign rem_o  = rem_q;
  assign root_o = root_q;

endmodule

/* design/cvf_div_cell.sv */
// One step of the restoring divider: shifts in one numerator bit, yields one quotient bit.
module cvf_div_cell #(
  parameter int unsigned QW = 17
) (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic [cvf_pkg::DenBits-1:0]   den_i,
  input  logic [cvf_pkg::DenBits-1:0]   rem_i,
  input  logic                          nbit_i,
  input  logic [QW-1:0]                 q_i,
  output logic [cvf_pkg::DenBits-1:0]   den_o,
  output logic [cvf_pkg::DenBits-1:0]   rem_o,
  output logic [QW-1:0]                 q_o
);

  logic [cvf_pkg::DenBits:0]   r2, diff;
  logic                        take;
  logic [cvf_pkg::DenBits-1:0] den_q, rem_d, rem_q;
  logic [QW-1:0]               q_d, q_q;

  // Remainder stays below the divisor, so the shifted value fits one extra bit.
  always_comb begin
    r2    = {rem_i, nbit_i};
    diff  = r2 - {1'b0, den_i};
    take  = (r2 >= {1'b0, den_i});
    rem_d = take ? diff[cvf_pkg::DenBits-1:0] : r2[cvf_pkg::DenBits-1:0];
    q_d   = {q_i[QW-2:0], take};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      den_q <= den_i;
      rem_q <= rem_d;
      q_q   <= q_d;
    end
  end

  assign den_o = den_q;
  assign rem_o = rem_q;
  assign q_o   = q_q;

endmodule

/* design/canyon_view_factors.sv */
// Top level: streaming 2D urban canyon view factor pipeline.
//
// Input channel in_valid_i/in_ready_o carries one grid cell per transaction
// (urban flag, building height H, road width W); output channel
// out_valid_o/out_ready_i returns one result per cell, in order: five view
// factors with FRAC_BITS fraction bits (masked to 17 bits) and a class code.
// cfg_we_i writes the degenerate-size threshold from cfg_wdata_i. The
// pipeline runs class decode, normalization, squaring and summing, then
// 32 square root cells, a register to form S + H, FRAC_BITS + 1 divider
// cells and the output register. Throughput is one cell per cycle while
// the pipeline advances; each cell of the root and divider chains retires
// one result bit per cycle. A stalled receiver holds the output register;
// the pipeline keeps moving into empty slots ahead of it and freezes only
// when its last stage holds an item that cannot drain. Reset empties the
// pipeline and sets the threshold to 1.
module canyon_view_factors #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  cvf_pkg::in_item_t             in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output cvf_pkg::out_item_t            out_data_o,
  input  logic                          cfg_we_i,
  input  logic [cvf_pkg::DimBits-1:0]   cfg_wdata_i
);

  localparam int unsigned QW     = FRAC_BITS + 1;
  localparam int unsigned NStage = 4 + cvf_pkg::SqrtSteps + 1 + QW;
  localparam int unsigned XW     = (QW > cvf_pkg::OutBits) ? QW : cvf_pkg::OutBits;
  localparam int unsigned NB     = cvf_pkg::NormBits;

  // Threshold register
  logic [cvf_pkg::DimBits-1:0] min_dim_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_dim_q <= cvf_pkg::DimBits'(1);
    end else if (cfg_we_i) begin
      min_dim_q <= cfg_wdata_i;
    end
  end

  // Flow control
  logic              out_valid_q;
  logic [NStage-1:0] v_q;
  logic              out_free, adv, in_fire;

  assign out_free   = !out_valid_q || out_ready_i;
  assign adv        = out_free || !v_q[NStage-1];
  assign in_ready_o = adv;
  assign in_fire    = in_valid_i && adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv) begin
      v_q <= {v_q[NStage-2:0], in_fire};
    end
  end

  // Stage A: classify and find normalization shift
  cvf_pkg::cell_class_e        cls_a_d, cls_a_q;
  logic [cvf_pkg::DimBits-1:0] h_a_q, w_a_q, max_a;
  logic [cvf_pkg::LzBits-1:0]  lz_a_q;

  always_comb begin
    if (!in_data_i.urban_flag) begin
      cls_a_d = cvf_pkg::ClassNonUrban;
    end else if ((in_data_i.building_height < min_dim_q) ||
                 (in_data_i.road_width < min_dim_q) ||
                 ((in_data_i.building_height == '0) && (in_data_i.road_width == '0))) begin
      cls_a_d = cvf_pkg::ClassDegenerate;
    end else begin
      cls_a_d = cvf_pkg::ClassRegular;
    end
    max_a = (in_data_i.building_height > in_data_i.road_width) ?
            in_data_i.building_height : in_data_i.road_width;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      cls_a_q <= cls_a_d;
      h_a_q   <= in_data_i.building_height;
      w_a_q   <= in_data_i.road_width;
      lz_a_q  <= cvf_pkg::lead_zeros(max_a);
    end
  end

  // Stage B: shift so the larger dimension has its top bit at NB-1
  cvf_pkg::cell_class_e       cls_b_q;
  logic [NB-1:0]              hn_b_q, wn_b_q;
  logic [cvf_pkg::LzBits-1:0] shamt_b;

  assign shamt_b = cvf_pkg::LzBits'(NB - cvf_pkg::DimBits) + lz_a_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      cls_b_q <= cls_a_q;
      hn_b_q  <= NB'(h_a_q) << shamt_b;
      wn_b_q  <= NB'(w_a_q) << shamt_b;
    end
  end

  // Stage C: squares
  cvf_pkg::cell_class_e        cls_c_q;
  logic [NB-1:0]               hn_c_q, wn_c_q;
  logic [cvf_pkg::SqBits-1:0]  hh_c_q, ww_c_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      cls_c_q <= cls_b_q;
      hn_c_q  <= hn_b_q;
      wn_c_q  <= wn_b_q;
      hh_c_q  <= hn_b_q * hn_b_q;
      ww_c_q  <= wn_b_q * wn_b_q;
    end
  end

  // Stage D: sum of squares
  cvf_pkg::sqrt_side_t        side_d_q;
  logic [cvf_pkg::SqBits:0]   n_d_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      side_d_q <= '{cls: cls_c_q, hn: hn_c_q, wn: wn_c_q};
      n_d_q    <= {1'b0, hh_c_q} + {1'b0, ww_c_q};
    end
  end

  // Square root chain
  logic [cvf_pkg::RadBits-1:0]   rad_c  [0:cvf_pkg::SqrtSteps];
  logic [cvf_pkg::SqRemBits-1:0] srem_c [0:cvf_pkg::SqrtSteps];
  logic [cvf_pkg::RootBits-1:0]  root_c [0:cvf_pkg::SqrtSteps];
  cvf_pkg::sqrt_side_t           sside_q [0:cvf_pkg::SqrtSteps-1];

  assign rad_c[0]  = cvf_pkg::RadBits'(n_d_q);
  assign srem_c[0] = '0;
  assign root_c[0] = '0;

  for (genvar k = 0; k < cvf_pkg::SqrtSteps; k++) begin : g_sqrt
    cvf_sqrt_cell u_cell (
      .clk_i  (clk_i),
      .en_i   (adv),
      .rad_i  (rad_c[k]),
      .rem_i  (srem_c[k]),
      .root_i (root_c[k]),
      .rad_o  (rad_c[k+1]),
      .rem_o  (srem_c[k+1]),
      .root_o (root_c[k+1])
    );

    always_ff @(posedge clk_i) begin
      if (adv) begin
        sside_q[k] <= (k == 0) ? side_d_q : sside_q[(k == 0) ? 0 : k-1];
      end
    end
  end

  // Stage E: divisor S + H
  cvf_pkg::cell_class_e        cls_e_q;
  logic [cvf_pkg::DenBits-1:0] den_e_q;
  logic [NB-1:0]               wn_e_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      cls_e_q <= sside_q[cvf_pkg::SqrtSteps-1].cls;
      wn_e_q  <= sside_q[cvf_pkg::SqrtSteps-1].wn;
      den_e_q <= cvf_pkg::DenBits'(root_c[cvf_pkg::SqrtSteps]) +
                 cvf_pkg::DenBits'(sside_q[cvf_pkg::SqrtSteps-1].hn);
    end
  end

  // Divider chain: W is at most the divisor, so the quotient fits QW bits
  logic [cvf_pkg::DenBits-1:0] den_c  [0:QW];
  logic [cvf_pkg::DenBits-1:0] drem_c [0:QW];
  logic [QW-1:0]               q_c    [0:QW];
  cvf_pkg::cell_class_e        dcls_q [0:QW-1];

  assign den_c[0]  = den_e_q;
  assign drem_c[0] = cvf_pkg::DenBits'(wn_e_q >> 1);
  assign q_c[0]    = '0;

  for (genvar k = 0; k < QW; k++) begin : g_div
    cvf_div_cell #(
      .QW (QW)
    ) u_cell (
      .clk_i  (clk_i),
      .en_i   (adv),
      .den_i  (den_c[k]),
      .rem_i  (drem_c[k]),
      .nbit_i ((k == 0) ? wn_e_q[0] : 1'b0),
      .q_i    (q_c[k]),
      .den_o  (den_c[k+1]),
      .rem_o  (drem_c[k+1]),
      .q_o    (q_c[k+1])
    );

    always_ff @(posedge clk_i) begin
      if (adv) begin
        dcls_q[k] <= (k == 0) ? cls_e_q : dcls_q[(k == 0) ? 0 : k-1];
      end
    end
  end

  // Final factors
  logic [QW-1:0]              one_v, rs, side_f;
  logic [XW-1:0]              rs_x, side_x, one_x;
  cvf_pkg::out_item_t         res_d, out_q;
  cvf_pkg::cell_class_e       cls_f;

  always_comb begin
    one_v  = QW'(1) << FRAC_BITS;
    rs     = (q_c[QW] > one_v) ? one_v : q_c[QW];
    side_f = (one_v - rs) >> 1;
    rs_x   = XW'(rs);
    side_x = XW'(side_f);
    one_x  = XW'(one_v);
    cls_f  = dcls_q[QW-1];
    res_d  = '0;
    res_d.cell_class = cls_f;
    case (cls_f)
      cvf_pkg::ClassDegenerate: begin
        res_d.wall_to_sky = one_x[cvf_pkg::OutBits-1:0];
        res_d.road_to_sky = one_x[cvf_pkg::OutBits-1:0];
      end
      cvf_pkg::ClassRegular: begin
        res_d.wall_to_sky  = side_x[cvf_pkg::OutBits-1:0];
        res_d.wall_to_wall = rs_x[cvf_pkg::OutBits-1:0];
        res_d.wall_to_road = side_x[cvf_pkg::OutBits-1:0];
        res_d.road_to_sky  = rs_x[cvf_pkg::OutBits-1:0];
        res_d.road_to_wall = side_x[cvf_pkg::OutBits-1:0];
      end
      default: begin
        res_d.cell_class = cvf_pkg::ClassNonUrban;
      end
    endcase
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= v_q[NStage-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      out_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
